// ===== rtl/fmp_pkg.sv =====
`timescale 1ns / 1ps
// shared widths, constants and types for the radix 2^51 field multiplier
// no dependencies
package fmp_pkg;

    localparam int NLIMB   = 5;
    localparam int IN_W    = 52;
    localparam int LIMB_W  = 51;
    localparam int HALF_W  = 26;
    localparam int PP_W    = 2 * HALF_W;
    localparam int PROD_W  = 2 * IN_W;
    localparam int COL_W   = 111;
    localparam int CARRY_W = COL_W - LIMB_W;
    localparam int WIDE_W  = 64;
    localparam int FOLD    = 19;

    typedef logic [NLIMB-1:0][IN_W-1:0]                   t_limbs;
    typedef logic [NLIMB-1:0][NLIMB-1:0][3:0][PP_W-1:0]   t_pps;
    typedef logic [NLIMB-1:0][NLIMB-1:0][PROD_W-1:0]      t_prods;
    typedef logic [NLIMB-1:0][COL_W-1:0]                  t_cols;

    typedef struct packed {
        logic [NLIMB-1:0][COL_W-1:0] col;
        logic [CARRY_W-1:0]          c;
    } t_cry;

endpackage

// ===== rtl/fmp_mul.sv =====
`timescale 1ns / 1ps
// two-stage 5x5 limb multiplier: 26x26 partial products, then 104-bit products
// depends on fmp_pkg
module fmp_mul import fmp_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_stall,
    input  t_limbs i_a,
    input  t_limbs i_b,
    output logic   o_valid,
    input  logic   i_stall,
    output t_prods o_prod
);

    logic   r_v1, r_v2;
    logic   en1, en2;
    t_pps   r_pp, n_pp;
    t_prods r_prod, n_prod;

    assign en2     = !r_v2 || !i_stall;
    assign en1     = !r_v1 || en2;
    assign o_stall = !en1;
    assign o_valid = r_v2;
    assign o_prod  = r_prod;

    always_comb begin
        for (int i = 0; i < NLIMB; i++) begin
            for (int j = 0; j < NLIMB; j++) begin
                n_pp[i][j][0] = PP_W'(i_a[i][HALF_W-1:0]) * PP_W'(i_b[j][HALF_W-1:0]);
                n_pp[i][j][1] = PP_W'(i_a[i][HALF_W-1:0]) * PP_W'(i_b[j][IN_W-1:HALF_W]);
                n_pp[i][j][2] = PP_W'(i_a[i][IN_W-1:HALF_W]) * PP_W'(i_b[j][HALF_W-1:0]);
                n_pp[i][j][3] = PP_W'(i_a[i][IN_W-1:HALF_W]) * PP_W'(i_b[j][IN_W-1:HALF_W]);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < NLIMB; i++) begin
            for (int j = 0; j < NLIMB; j++) begin
                n_prod[i][j] = PROD_W'(r_pp[i][j][0])
                             + (PROD_W'(r_pp[i][j][1]) << HALF_W)
                             + (PROD_W'(r_pp[i][j][2]) << HALF_W)
                             + (PROD_W'(r_pp[i][j][3]) << PP_W);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) r_pp <= n_pp;
        if (en2) r_prod <= n_prod;
    end

endmodule

// ===== rtl/fmp_col.sv =====
`timescale 1ns / 1ps
// two-stage column summation: low and high column sums, then fold by 19
// depends on fmp_pkg
module fmp_col import fmp_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_stall,
    input  t_prods i_prod,
    output logic   o_valid,
    input  logic   i_stall,
    output t_cols  o_col
);

    logic  r_v3, r_v4;
    logic  en3, en4;
    t_cols r_lo, n_lo;
    t_cols r_hi, n_hi;
    t_cols r_col, n_col;

    assign en4     = !r_v4 || !i_stall;
    assign en3     = !r_v3 || en4;
    assign o_stall = !en3;
    assign o_valid = r_v4;
    assign o_col   = r_col;

    // column k takes i+j == k, and i+j == k+5 into the part folded by 19
    always_comb begin
        for (int k = 0; k < NLIMB; k++) begin
            n_lo[k] = '0;
            n_hi[k] = '0;
            for (int i = 0; i < NLIMB; i++) begin
                if (i <= k) begin
                    n_lo[k] = n_lo[k] + COL_W'(i_prod[i][k-i]);
                end else begin
                    n_hi[k] = n_hi[k] + COL_W'(i_prod[i][k+NLIMB-i]);
                end
            end
        end
    end

    // times 19 as 16 + 2 + 1
    always_comb begin
        for (int k = 0; k < NLIMB; k++) begin
            n_col[k] = r_lo[k] + (r_hi[k] << 4) + (r_hi[k] << 1) + r_hi[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en3) r_v3 <= i_valid;
            if (en4) r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_lo <= n_lo;
            r_hi <= n_hi;
        end
        if (en4) r_col <= n_col;
    end

endmodule

// ===== rtl/fmp_carry.sv =====
`timescale 1ns / 1ps
// seven-stage carry chain: one column carry per stage, top carry fold, last carry
// depends on fmp_pkg
module fmp_carry import fmp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  t_cols             i_col,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [LIMB_W-1:0] o_p_limb0,
    output logic [IN_W-1:0]   o_p_limb1,
    output logic [LIMB_W-1:0] o_p_limb2,
    output logic [LIMB_W-1:0] o_p_limb3,
    output logic [LIMB_W-1:0] o_p_limb4
);

    localparam int NSTG = NLIMB + 2;

    logic [NSTG-1:0]                    r_v;
    logic [NSTG-1:0]                    en;
    t_cry [NLIMB-1:0]                   r_cs, n_cs;
    logic [WIDE_W-1:0]                  r_h0, n_h0;
    logic [NLIMB-1:1][LIMB_W-1:0]       r_hl;
    logic [WIDE_W-1:0]                  n_h1;
    logic [LIMB_W-1:0]                  r_p0, r_p2, r_p3, r_p4;
    logic [IN_W-1:0]                    r_p1;

    always_comb begin
        en[NSTG-1] = !r_v[NSTG-1] || !i_stall;
        for (int s = NSTG - 2; s >= 0; s--) begin
            en[s] = !r_v[s] || en[s+1];
        end
    end

    assign o_stall = !en[0];
    assign o_valid = r_v[NSTG-1];

    always_comb begin
        logic [COL_W-1:0] t;
        t_cry             prev;
        for (int s = 0; s < NLIMB; s++) begin
            if (s == 0) begin
                prev.col = i_col;
                prev.c   = '0;
            end else begin
                prev = r_cs[s-1];
            end
            t              = prev.col[s] + COL_W'(prev.c);
            n_cs[s]        = prev;
            n_cs[s].col[s] = COL_W'(t[LIMB_W-1:0]);
            n_cs[s].c      = t[COL_W-1:LIMB_W];
        end
    end

    // top carry times 19 into limb 0, wrapping at 64 bits
    always_comb begin
        logic [WIDE_W-1:0] c64;
        c64  = WIDE_W'(r_cs[NLIMB-1].c);
        n_h0 = WIDE_W'(r_cs[NLIMB-1].col[0][LIMB_W-1:0])
             + (c64 << 4) + (c64 << 1) + c64;
    end

    assign n_h1 = WIDE_W'(r_hl[1]) + (r_h0 >> LIMB_W);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) r_v[0] <= i_valid;
            for (int s = 1; s < NSTG; s++) begin
                if (en[s]) r_v[s] <= r_v[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < NLIMB; s++) begin
            if (en[s]) r_cs[s] <= n_cs[s];
        end
        if (en[NLIMB]) begin
            r_h0 <= n_h0;
            for (int i = 1; i < NLIMB; i++) begin
                r_hl[i] <= r_cs[NLIMB-1].col[i][LIMB_W-1:0];
            end
        end
        if (en[NSTG-1]) begin
            r_p0 <= r_h0[LIMB_W-1:0];
            r_p1 <= n_h1[IN_W-1:0];
            r_p2 <= r_hl[2];
            r_p3 <= r_hl[3];
            r_p4 <= r_hl[4];
        end
    end

    assign o_p_limb0 = r_p0;
    assign o_p_limb1 = r_p1;
    assign o_p_limb2 = r_p2;
    assign o_p_limb3 = r_p3;
    assign o_p_limb4 = r_p4;

    a_top_carry_small: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[NLIMB-1] |-> r_cs[NLIMB-1].c[CARRY_W-1:56] == '0)
        else $error("top carry wider than expected");

    a_fold_no_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[NLIMB] |-> r_h0[WIDE_W-1:61] == '0)
        else $error("folded limb 0 too wide");

    a_limb1_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_p_limb1[IN_W-1:LIMB_W] == 1'b0 || o_p_limb1[LIMB_W-1:10] == '0)
        else $error("limb 1 exceeds partial reduction bound");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> r_v == '0)
        else $error("pipeline not empty after reset");

endmodule

// ===== rtl/field_mul_p25519_radix51.sv =====
`timescale 1ns / 1ps
// multiplier for the field modulo 2^255-19 in radix 2^51, top level
// depends on fmp_pkg, fmp_mul, fmp_col, fmp_carry
//
// usage
// - input channel: i_valid, o_stall and ten 52-bit operand limbs; a word is taken
//   at a rising edge with i_valid high and o_stall low
// - output channel: o_valid, i_stall and five product limbs, partly reduced:
//   limb 1 may carry up to about 2^10 above 51 bits
// - stages: 2 multiply, 2 column sum and fold, 5 column carries,
//   1 top carry fold, 1 last carry into limb 1
// - throughput one word per cycle while i_stall is low; every stage has its own valid bit and
//   loads when it is empty or its successor moves, so bubbles close up
// - when i_stall is high the output word holds and the stages behind it
//   fill; o_stall rises only once every stage holds a word
// - synchronous active-low reset empties the pipeline; there is no
//   configuration and no stored state between words
module field_mul_p25519_radix51 import fmp_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [IN_W-1:0]   i_a_limb0,
    input  logic [IN_W-1:0]   i_a_limb1,
    input  logic [IN_W-1:0]   i_a_limb2,
    input  logic [IN_W-1:0]   i_a_limb3,
    input  logic [IN_W-1:0]   i_a_limb4,
    input  logic [IN_W-1:0]   i_b_limb0,
    input  logic [IN_W-1:0]   i_b_limb1,
    input  logic [IN_W-1:0]   i_b_limb2,
    input  logic [IN_W-1:0]   i_b_limb3,
    input  logic [IN_W-1:0]   i_b_limb4,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [LIMB_W-1:0] o_p_limb0,
    output logic [IN_W-1:0]   o_p_limb1,
    output logic [LIMB_W-1:0] o_p_limb2,
    output logic [LIMB_W-1:0] o_p_limb3,
    output logic [LIMB_W-1:0] o_p_limb4
);

    t_limbs a, b;
    t_prods prod;
    t_cols  col;
    logic   mul_valid, mul_stall;
    logic   col_valid, col_stall;

    assign a = {i_a_limb4, i_a_limb3, i_a_limb2, i_a_limb1, i_a_limb0};
    assign b = {i_b_limb4, i_b_limb3, i_b_limb2, i_b_limb1, i_b_limb0};

    fmp_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_a     (a),
        .i_b     (b),
        .o_valid (mul_valid),
        .i_stall (mul_stall),
        .o_prod  (prod)
    );

    fmp_col u_col (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mul_valid),
        .o_stall (mul_stall),
        .i_prod  (prod),
        .o_valid (col_valid),
        .i_stall (col_stall),
        .o_col   (col)
    );

    fmp_carry u_carry (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (col_valid),
        .o_stall   (col_stall),
        .i_col     (col),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_p_limb0 (o_p_limb0),
        .o_p_limb1 (o_p_limb1),
        .o_p_limb2 (o_p_limb2),
        .o_p_limb3 (o_p_limb3),
        .o_p_limb4 (o_p_limb4)
    );

endmodule

// ===== test/field_mul_p25519_radix51_tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for field_mul_p25519_radix51, the radix 2^51 multiplier mod 2^255-19
// depends on fmp_pkg and the dut; directed table then random operands, checked by a predictor
module field_mul_p25519_radix51_tb;
    import fmp_pkg::*;

    localparam logic [IN_W-1:0] L_MAX = 52'hF_FFFF_FFFF_FFFF;
    localparam logic [IN_W-1:0] L_M51 = 52'h7_FFFF_FFFF_FFFF;
    localparam logic [IN_W-1:0] L_TOP = 52'h8_0000_0000_0000;
    localparam logic [IN_W-1:0] L_ALT = 52'hA_AAAA_AAAA_AAAA;
    localparam logic [IN_W-1:0] L_INV = 52'h5_5555_5555_5555;
    localparam int N_DIR      = 15;
    localparam int N_RAND     = 650;
    localparam int HOLD_LEN   = 80;
    localparam int DRAIN_MAX  = 5000;

    typedef struct {
        logic [IN_W-1:0] a [NLIMB];
        logic [IN_W-1:0] b [NLIMB];
        bit              known;
        logic [IN_W-1:0] p [NLIMB];
    } t_dir_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic [IN_W-1:0]   i_a_limb0, i_a_limb1, i_a_limb2, i_a_limb3, i_a_limb4;
    logic [IN_W-1:0]   i_b_limb0, i_b_limb1, i_b_limb2, i_b_limb3, i_b_limb4;
    logic              o_valid;
    logic              i_stall;
    logic [LIMB_W-1:0] o_p_limb0;
    logic [IN_W-1:0]   o_p_limb1;
    logic [LIMB_W-1:0] o_p_limb2;
    logic [LIMB_W-1:0] o_p_limb3;
    logic [LIMB_W-1:0] o_p_limb4;

    t_limbs   expected_products [$];
    t_limbs   oldest_product;
    int       fails;
    int       tx_idle_pct;
    int       rx_stall_pct;
    int       hold_trig;
    t_dir_row dir_tab [N_DIR];

    field_mul_p25519_radix51 dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_a_limb0 (i_a_limb0),
        .i_a_limb1 (i_a_limb1),
        .i_a_limb2 (i_a_limb2),
        .i_a_limb3 (i_a_limb3),
        .i_a_limb4 (i_a_limb4),
        .i_b_limb0 (i_b_limb0),
        .i_b_limb1 (i_b_limb1),
        .i_b_limb2 (i_b_limb2),
        .i_b_limb3 (i_b_limb3),
        .i_b_limb4 (i_b_limb4),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_p_limb0 (o_p_limb0),
        .o_p_limb1 (o_p_limb1),
        .o_p_limb2 (o_p_limb2),
        .o_p_limb3 (o_p_limb3),
        .o_p_limb4 (o_p_limb4)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // schoolbook product, high columns folded by 19, one carry chain, top carry folded by 19, last carry into limb 1
    function automatic t_limbs mul_mod_p25519(input t_limbs a, input t_limbs b);
        logic [127:0] col [NLIMB];
        logic [63:0]  bf [NLIMB];
        logic [63:0]  h [NLIMB];
        logic [63:0]  carry;
        t_limbs       p;
        int           i, j, k;
        for (i = 0; i < NLIMB; i++) begin
            bf[i] = 64'(b[i]) * 64'(FOLD);
        end
        for (i = 0; i < NLIMB; i++) begin
            col[i] = '0;
            for (j = 0; j < NLIMB; j++) begin
                k = i - j;
                if (k >= 0) begin
                    col[i] = col[i] + 128'(a[j]) * 128'(b[k]);
                end else begin
                    col[i] = col[i] + 128'(a[j]) * 128'(bf[k + NLIMB]);
                end
            end
        end
        carry = '0;
        for (i = 0; i < NLIMB; i++) begin
            col[i] = col[i] + 128'(carry);
            carry  = col[i][LIMB_W +: 64];
            h[i]   = 64'(col[i][LIMB_W-1:0]);
        end
        h[0] = h[0] + carry * 64'(FOLD);
        h[1] = h[1] + (h[0] >> LIMB_W);
        h[0] = h[0] & 64'(L_M51);
        for (i = 0; i < NLIMB; i++) begin
            p[i] = h[i][IN_W-1:0];
        end
        return p;
    endfunction

    function automatic logic [IN_W-1:0] rand_limb();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(9))
            0: return '0;
            1: return L_MAX;
            2: return L_M51;
            3: return L_TOP;
            default: return r[IN_W-1:0];
        endcase
    endfunction

    task automatic check_limb(input string name, input logic [IN_W-1:0] want,
                              input logic [IN_W-1:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %h, got %h", name, want, got);
            fails++;
        end
    endtask

    task automatic offer_operands(input t_limbs a, input t_limbs b, input t_limbs p);
        while ($urandom_range(99) < tx_idle_pct) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid   <= 1'b1;
        i_a_limb0 <= a[0];
        i_a_limb1 <= a[1];
        i_a_limb2 <= a[2];
        i_a_limb3 <= a[3];
        i_a_limb4 <= a[4];
        i_b_limb0 <= b[0];
        i_b_limb1 <= b[1];
        i_b_limb2 <= b[2];
        i_b_limb3 <= b[3];
        i_b_limb4 <= b[4];
        do @(posedge i_clk); while (o_stall);
        expected_products.push_back(p);
    endtask

    task automatic offer_random(input int count);
        t_limbs a, b;
        int     n, l;
        for (n = 0; n < count; n++) begin
            for (l = 0; l < NLIMB; l++) begin
                a[l] = rand_limb();
                b[l] = rand_limb();
            end
            offer_operands(a, b, mul_mod_p25519(a, b));
        end
    endtask

    // receiver: random stalls, plus one long hold when asked for
    initial begin
        int seen, left;
        seen    = 0;
        left    = 0;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_trig != seen) begin
                seen = hold_trig;
                left = HOLD_LEN;
            end
            if (left > 0) begin
                left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < rx_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_products.size() == 0) begin
                $error("product word with none expected");
                fails++;
            end else begin
                oldest_product = expected_products.pop_front();
                check_limb("p_limb0", oldest_product[0], IN_W'(o_p_limb0));
                check_limb("p_limb1", oldest_product[1], o_p_limb1);
                check_limb("p_limb2", oldest_product[2], IN_W'(o_p_limb2));
                check_limb("p_limb3", oldest_product[3], IN_W'(o_p_limb3));
                check_limb("p_limb4", oldest_product[4], IN_W'(o_p_limb4));
            end
        end
    end

    initial begin
        t_limbs a, b, p;
        int     r, l, waited;
        fails        = 0;
        hold_trig    = 0;
        tx_idle_pct  = 38;
        rx_stall_pct = 51;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_a_limb0    = '0;
        i_a_limb1    = '0;
        i_a_limb2    = '0;
        i_a_limb3    = '0;
        i_a_limb4    = '0;
        i_b_limb0    = '0;
        i_b_limb1    = '0;
        i_b_limb2    = '0;
        i_b_limb3    = '0;
        i_b_limb4    = '0;

        // limbs listed from limb 0 up to limb 4
        dir_tab = '{
            '{'{0, 0, 0, 0, 0}, '{0, 0, 0, 0, 0}, 1'b1, '{0, 0, 0, 0, 0}},
            '{'{1, 0, 0, 0, 0}, '{1, 0, 0, 0, 0}, 1'b1, '{1, 0, 0, 0, 0}},
            '{'{0, 0, 0, 0, 0}, '{L_MAX, L_MAX, L_MAX, L_MAX, L_MAX}, 1'b1,
              '{0, 0, 0, 0, 0}},
            '{'{0, 0, 0, 0, 1}, '{0, 1, 0, 0, 0}, 1'b1, '{19, 0, 0, 0, 0}},
            '{'{0, 0, 1, 0, 0}, '{0, 0, 1, 0, 0}, 1'b1, '{0, 0, 0, 0, 1}},
            '{'{0, 0, 0, 1, 0}, '{0, 0, 0, 1, 0}, 1'b1, '{0, 19, 0, 0, 0}},
            '{'{L_MAX, L_MAX, L_MAX, L_MAX, L_MAX}, '{L_MAX, L_MAX, L_MAX, L_MAX, L_MAX},
              1'b0, '{0, 0, 0, 0, 0}},
            '{'{L_M51, L_M51, L_M51, L_M51, L_M51}, '{L_M51, L_M51, L_M51, L_M51, L_M51},
              1'b0, '{0, 0, 0, 0, 0}},
            '{'{L_TOP, L_TOP, L_TOP, L_TOP, L_TOP}, '{L_TOP, L_TOP, L_TOP, L_TOP, L_TOP},
              1'b0, '{0, 0, 0, 0, 0}},
            '{'{L_M51, L_M51, L_M51, L_M51, L_M51}, '{L_MAX, L_MAX, L_MAX, L_MAX, L_MAX},
              1'b0, '{0, 0, 0, 0, 0}},
            '{'{L_MAX, 0, L_MAX, 0, L_MAX}, '{0, L_MAX, 0, L_MAX, 0}, 1'b0,
              '{0, 0, 0, 0, 0}},
            '{'{1, 0, 0, 0, 0}, '{L_MAX, L_MAX, L_MAX, L_MAX, L_MAX}, 1'b0,
              '{0, 0, 0, 0, 0}},
            '{'{0, 0, 0, 0, L_MAX}, '{0, 0, 0, 0, L_MAX}, 1'b0, '{0, 0, 0, 0, 0}},
            '{'{19, 0, 0, 0, 0}, '{L_M51, L_M51, L_M51, L_M51, L_TOP}, 1'b0,
              '{0, 0, 0, 0, 0}},
            '{'{L_ALT, L_INV, L_ALT, L_INV, L_ALT}, '{L_INV, L_ALT, L_INV, L_ALT, L_INV},
              1'b0, '{0, 0, 0, 0, 0}}
        };

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (r = 0; r < N_DIR; r++) begin
            for (l = 0; l < NLIMB; l++) begin
                a[l] = dir_tab[r].a[l];
                b[l] = dir_tab[r].b[l];
                p[l] = dir_tab[r].p[l];
            end
            if (!dir_tab[r].known) begin
                p = mul_mod_p25519(a, b);
            end
            offer_operands(a, b, p);
        end
        offer_random(N_RAND);

        tx_idle_pct  = 51;
        rx_stall_pct = 38;
        offer_random(N_RAND);

        // full rate, with one long hold at the output so the pipeline backs up
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_trig    = hold_trig + 1;
        offer_random(N_RAND);

        @(negedge i_clk);
        i_valid <= 1'b0;

        waited = 0;
        while (expected_products.size() != 0 && waited < DRAIN_MAX) begin
            @(posedge i_clk);
            waited++;
        end
        if (expected_products.size() != 0) begin
            $error("%0d product words never arrived", expected_products.size());
            fails++;
        end
        repeat (20) @(posedge i_clk);

        if (fails == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/fmp_pkg.sv
rtl/fmp_mul.sv
rtl/fmp_col.sv
rtl/fmp_carry.sv
rtl/field_mul_p25519_radix51.sv
test/field_mul_p25519_radix51_tb.sv
